// ===== src/convex_hull_monotone_chain_unit_defines.svh =====
// Assertion macros shared by the hull unit.
`ifndef CONVEX_HULL_MONOTONE_CHAIN_UNIT_DEFINES_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_UNIT_DEFINES_SVH
`ifndef SYNTH
`define CHM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("hull unit check failed");
`define CHM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("hull unit check failed");
`define CHM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("hull unit check failed");
`else
`define CHM_ASSERT(lbl, clk, rstn, prop)
`define CHM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CHM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== src/chm_pkg.sv =====
package chm_pkg;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SORT_K,
    S_SORT_LD,
    S_SORT_RD,
    S_SORT_CMP,
    S_SORT_PUT,
    S_H_RF,
    S_H_RL,
    S_H_INIT,
    S_H_RP,
    S_H_LP,
    S_H_MUL,
    S_H_DEC,
    S_C_CHK,
    S_C_RI,
    S_C_RP,
    S_C_MUL,
    S_C_DEC,
    S_C_PUSH,
    S_E_SEL,
    S_E_RI,
    S_E_OUT
  } chm_state_e;

  typedef struct packed {
    logic pos;
    logic neg;
  } chm_turn_t;

endpackage

// ===== src/chm_front.sv =====
module chm_front #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [COORD_BITS-1:0]   x_i,
  input  logic [COORD_BITS-1:0]   y_i,
  input  logic                    last_i,
  input  logic                    full_i,
  output logic                    push_o,
  output logic [2*COORD_BITS+1:0] entry_o
);

  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          store;

  assign store   = cnt_q < CW'(MAX_POINTS);
  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;
  assign entry_o = {store, last_i, y_i, x_i};

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (last_i) begin
        cnt_d = '0;
      end else if (store) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/chm_fifo.sv =====
module chm_fifo #(
  parameter int unsigned Width = 34,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [NW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == NW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wp_d = (wp_q == PW'(Depth - 1)) ? '0 : wp_q + PW'(1);
    end
    if (do_pop) begin
      rp_d = (rp_q == PW'(Depth - 1)) ? '0 : rp_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + NW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule

// ===== src/chm_turn.sv =====
module chm_turn #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic [2*COORD_BITS-1:0] a_i,
  input  logic [2*COORD_BITS-1:0] b_i,
  input  logic [2*COORD_BITS-1:0] c_i,
  output chm_pkg::chm_turn_t      turn_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned PW = 2 * CB + 2;

  logic signed [CB:0]   ux, uy, vx, vy;
  logic signed [PW-1:0] p_d, q_d, p_q, q_q;

  assign ux = $signed({a_i[CB-1], a_i[CB-1:0]}) - $signed({b_i[CB-1], b_i[CB-1:0]});
  assign uy = $signed({a_i[2*CB-1], a_i[2*CB-1:CB]}) - $signed({b_i[2*CB-1], b_i[2*CB-1:CB]});
  assign vx = $signed({c_i[CB-1], c_i[CB-1:0]}) - $signed({b_i[CB-1], b_i[CB-1:0]});
  assign vy = $signed({c_i[2*CB-1], c_i[2*CB-1:CB]}) - $signed({b_i[2*CB-1], b_i[2*CB-1:CB]});
  assign p_d = ux * vy;
  assign q_d = uy * vx;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    q_q <= q_d;
  end

  assign turn_o.pos = p_q > q_q;
  assign turn_o.neg = p_q < q_q;

endmodule

// ===== src/chm_back.sv =====
`include "convex_hull_monotone_chain_unit_defines.svh"

module chm_back #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fifo_valid_i,
  input  logic [2*COORD_BITS+1:0] fifo_data_i,
  output logic                    fifo_pop_o,
  output logic                    m_valid_o,
  input  logic                    m_ready_i,
  output logic [2*COORD_BITS-1:0] m_data_o,
  output logic                    m_last_o,
  output logic                    m_ovf_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = 2 * CB;
  localparam int unsigned IW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned TW = CW + 1;

  chm_pkg::chm_state_e st_q, st_d;
  chm_pkg::chm_turn_t  trn;

  logic [DW-1:0] pmem_q [MAX_POINTS];
  logic [IW-1:0] umem_q [MAX_POINTS];
  logic [IW-1:0] lmem_q [MAX_POINTS];

  logic          pwe, uwe, lwe;
  logic [IW-1:0] pwa, cwa, cwd, pra, prb, cra, crb;
  logic [DW-1:0] pwd, prd_a_q, prd_b_q;
  logic [IW-1:0] urd_a_q, urd_b_q, lrd_a_q, lrd_b_q;

  logic [CW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, k_q, k_d, utop_q, utop_d, ltop_q, ltop_d;
  logic          ovf_q, ovf_d, side_q, side_d, lo_q, lo_d, dou_q, dou_d, dol_q, dol_d;
  logic [DW-1:0] key_q, key_d, p_q, p_d, first_q, first_d, lastp_q, lastp_d;
  logic [DW-1:0] ta_q, ta_d, tb_q, tb_d, tc_q, tc_d;
  logic [IW-1:0] idx_q, idx_d;
  logic          ov_q, ov_d, olast_q, olast_d, oovf_q, oovf_d;
  logic [DW-1:0] odata_q, odata_d;

  logic          in_store, in_last, small_set, key_first, more_pts, do_side, side_bad;
  logic          out_load, out_last, emit_up, emit_lo;
  logic [CW-1:0] ip1, jm1, nm1, top, tm1, tm2, n_new, lstart;
  logic [TW-1:0] total;
  logic [IW-1:0] chain_a;

  chm_turn #(.COORD_BITS(COORD_BITS)) u_turn (
    .clk_i  (clk_i),
    .a_i    (ta_q),
    .b_i    (tb_q),
    .c_i    (tc_q),
    .turn_o (trn)
  );

  assign in_store  = fifo_data_i[DW+1];
  assign in_last   = fifo_data_i[DW];
  assign n_new     = in_store ? n_q + CW'(1) : n_q;
  assign small_set = n_new <= CW'(1);
  assign ip1       = i_q + CW'(1);
  assign jm1       = j_q - CW'(1);
  assign nm1       = n_q - CW'(1);
  assign more_pts  = ip1 < n_q;
  assign top       = side_q ? ltop_q : utop_q;
  assign tm1       = top - CW'(1);
  assign tm2       = top - CW'(2);
  assign do_side   = side_q ? dol_q : dou_q;
  assign side_bad  = side_q ? !trn.neg : !trn.pos;
  assign chain_a   = lo_q ? lrd_a_q : urd_a_q;
  assign lstart    = (ltop_q >= CW'(2)) ? ltop_q - CW'(2) : '0;
  assign total     = TW'(utop_q) + TW'(lstart);
  assign out_last  = (TW'(k_q) + TW'(1)) == total;
  assign out_load  = (st_q == chm_pkg::S_E_OUT) && (!ov_q || m_ready_i);
  assign emit_up   = (j_q < utop_q) && (k_q < CW'(MAX_POINTS));
  assign emit_lo   = (j_q != '0) && (k_q < CW'(MAX_POINTS));
  assign key_first = ($signed(key_q[CB-1:0]) < $signed(prd_a_q[CB-1:0])) ||
                     ((key_q[CB-1:0] == prd_a_q[CB-1:0]) &&
                      ($signed(key_q[DW-1:CB]) < $signed(prd_a_q[DW-1:CB])));

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      chm_pkg::S_IDLE: begin
        if (fifo_valid_i && in_last) begin
          st_d = small_set ? chm_pkg::S_E_SEL : chm_pkg::S_SORT_K;
        end
      end
      chm_pkg::S_SORT_K:   st_d = chm_pkg::S_SORT_LD;
      chm_pkg::S_SORT_LD:  st_d = chm_pkg::S_SORT_RD;
      chm_pkg::S_SORT_RD:  st_d = chm_pkg::S_SORT_CMP;
      chm_pkg::S_SORT_CMP: begin
        st_d = (key_first && (jm1 != '0)) ? chm_pkg::S_SORT_RD : chm_pkg::S_SORT_PUT;
      end
      chm_pkg::S_SORT_PUT: st_d = more_pts ? chm_pkg::S_SORT_K : chm_pkg::S_H_RF;
      chm_pkg::S_H_RF:     st_d = chm_pkg::S_H_RL;
      chm_pkg::S_H_RL:     st_d = chm_pkg::S_H_INIT;
      chm_pkg::S_H_INIT:   st_d = chm_pkg::S_H_RP;
      chm_pkg::S_H_RP:     st_d = chm_pkg::S_H_LP;
      chm_pkg::S_H_LP:     st_d = chm_pkg::S_H_MUL;
      chm_pkg::S_H_MUL:    st_d = chm_pkg::S_H_DEC;
      chm_pkg::S_H_DEC:    st_d = chm_pkg::S_C_CHK;
      chm_pkg::S_C_CHK: begin
        if (do_side) begin
          st_d = (top >= CW'(2)) ? chm_pkg::S_C_RI : chm_pkg::S_C_PUSH;
        end else if (side_q) begin
          st_d = more_pts ? chm_pkg::S_H_RP : chm_pkg::S_E_SEL;
        end
      end
      chm_pkg::S_C_RI:     st_d = chm_pkg::S_C_RP;
      chm_pkg::S_C_RP:     st_d = chm_pkg::S_C_MUL;
      chm_pkg::S_C_MUL:    st_d = chm_pkg::S_C_DEC;
      chm_pkg::S_C_DEC:    st_d = side_bad ? chm_pkg::S_C_CHK : chm_pkg::S_C_PUSH;
      chm_pkg::S_C_PUSH:   st_d = chm_pkg::S_C_CHK;
      chm_pkg::S_E_SEL: begin
        if (!lo_q && emit_up) begin
          st_d = chm_pkg::S_E_RI;
        end else if (lo_q) begin
          st_d = emit_lo ? chm_pkg::S_E_RI : chm_pkg::S_IDLE;
        end
      end
      chm_pkg::S_E_RI:     st_d = chm_pkg::S_E_OUT;
      chm_pkg::S_E_OUT: begin
        if (out_load) begin
          st_d = out_last ? chm_pkg::S_IDLE : chm_pkg::S_E_SEL;
        end
      end
      default:             st_d = chm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    fifo_pop_o = 1'b0;
    pwe = 1'b0;
    pwa = j_q[IW-1:0];
    pwd = key_q;
    uwe = 1'b0;
    lwe = 1'b0;
    cwa = top[IW-1:0];
    cwd = i_q[IW-1:0];
    pra = i_q[IW-1:0];
    prb = '0;
    cra = tm2[IW-1:0];
    crb = tm1[IW-1:0];
    unique case (st_q)
      chm_pkg::S_IDLE: begin
        fifo_pop_o = fifo_valid_i;
        pwa = n_q[IW-1:0];
        pwd = fifo_data_i[DW-1:0];
        pwe = fifo_valid_i && in_store;
        cwa = '0;
        cwd = '0;
        uwe = fifo_valid_i && in_last && small_set;
      end
      chm_pkg::S_SORT_RD:  pra = jm1[IW-1:0];
      chm_pkg::S_SORT_CMP: begin
        pwd = prd_a_q;
        pwe = key_first;
      end
      chm_pkg::S_SORT_PUT: pwe = 1'b1;
      chm_pkg::S_H_RF:     pra = '0;
      chm_pkg::S_H_RL:     pra = nm1[IW-1:0];
      chm_pkg::S_H_INIT: begin
        cwa = '0;
        cwd = '0;
        uwe = 1'b1;
        lwe = 1'b1;
      end
      chm_pkg::S_C_RI: begin
        pra = side_q ? lrd_a_q : urd_a_q;
        prb = side_q ? lrd_b_q : urd_b_q;
      end
      chm_pkg::S_C_PUSH: begin
        uwe = !side_q && (top < CW'(MAX_POINTS));
        lwe = side_q && (top < CW'(MAX_POINTS));
      end
      chm_pkg::S_E_SEL: begin
        cra = j_q[IW-1:0];
      end
      chm_pkg::S_E_RI:     pra = chain_a;
      chm_pkg::S_E_OUT:    pra = idx_q;
      default: begin
      end
    endcase
  end

  always_comb begin
    n_d = n_q;
    ovf_d = ovf_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    utop_d = utop_q;
    ltop_d = ltop_q;
    side_d = side_q;
    lo_d = lo_q;
    dou_d = dou_q;
    dol_d = dol_q;
    key_d = key_q;
    p_d = p_q;
    first_d = first_q;
    lastp_d = lastp_q;
    ta_d = ta_q;
    tb_d = tb_q;
    tc_d = tc_q;
    idx_d = idx_q;
    odata_d = odata_q;
    olast_d = olast_q;
    oovf_d = oovf_q;
    ov_d = (m_ready_i) ? 1'b0 : ov_q;
    unique case (st_q)
      chm_pkg::S_IDLE: begin
        if (fifo_valid_i) begin
          n_d = n_new;
          if (!in_store) begin
            ovf_d = 1'b1;
          end
          if (in_last) begin
            i_d = CW'(1);
            j_d = '0;
            k_d = '0;
            lo_d = 1'b0;
            if (small_set) begin
              utop_d = CW'(1);
              ltop_d = '0;
            end
          end
        end
      end
      chm_pkg::S_SORT_LD: begin
        key_d = prd_a_q;
        j_d = i_q;
      end
      chm_pkg::S_SORT_CMP: begin
        if (key_first) begin
          j_d = jm1;
        end
      end
      chm_pkg::S_SORT_PUT: i_d = more_pts ? ip1 : CW'(1);
      chm_pkg::S_H_RL:     first_d = prd_a_q;
      chm_pkg::S_H_INIT: begin
        lastp_d = prd_a_q;
        utop_d = CW'(1);
        ltop_d = CW'(1);
      end
      chm_pkg::S_H_LP: begin
        p_d = prd_a_q;
        ta_d = first_q;
        tb_d = lastp_q;
        tc_d = prd_a_q;
      end
      chm_pkg::S_H_DEC: begin
        dou_d = (i_q == nm1) || trn.neg;
        dol_d = (i_q == nm1) || trn.pos;
        side_d = 1'b0;
      end
      chm_pkg::S_C_CHK: begin
        if (!do_side) begin
          if (!side_q) begin
            side_d = 1'b1;
          end else begin
            i_d = ip1;
            j_d = '0;
            k_d = '0;
            lo_d = 1'b0;
          end
        end
      end
      chm_pkg::S_C_RP: begin
        ta_d = prd_a_q;
        tb_d = prd_b_q;
        tc_d = p_q;
      end
      chm_pkg::S_C_DEC: begin
        if (side_bad) begin
          if (side_q) begin
            ltop_d = tm1;
          end else begin
            utop_d = tm1;
          end
        end
      end
      chm_pkg::S_C_PUSH: begin
        if (top < CW'(MAX_POINTS)) begin
          if (side_q) begin
            ltop_d = top + CW'(1);
          end else begin
            utop_d = top + CW'(1);
          end
        end
        if (side_q) begin
          dol_d = 1'b0;
        end else begin
          dou_d = 1'b0;
        end
      end
      chm_pkg::S_E_SEL: begin
        if (!lo_q && !emit_up) begin
          lo_d = 1'b1;
          j_d = lstart;
        end else if (lo_q && !emit_lo) begin
          n_d = '0;
          ovf_d = 1'b0;
          utop_d = '0;
          ltop_d = '0;
        end
      end
      chm_pkg::S_E_RI:     idx_d = chain_a;
      chm_pkg::S_E_OUT: begin
        if (out_load) begin
          ov_d = 1'b1;
          odata_d = prd_a_q;
          olast_d = out_last;
          oovf_d = ovf_q;
          k_d = k_q + CW'(1);
          j_d = lo_q ? jm1 : j_q + CW'(1);
          if (out_last) begin
            n_d = '0;
            ovf_d = 1'b0;
            utop_d = '0;
            ltop_d = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= chm_pkg::S_IDLE;
      n_q <= '0;
      ovf_q <= 1'b0;
      utop_q <= '0;
      ltop_q <= '0;
      ov_q <= 1'b0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
      side_q <= 1'b0;
      lo_q <= 1'b0;
      dou_q <= 1'b0;
      dol_q <= 1'b0;
    end else begin
      st_q <= st_d;
      n_q <= n_d;
      ovf_q <= ovf_d;
      utop_q <= utop_d;
      ltop_q <= ltop_d;
      ov_q <= ov_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
      side_q <= side_d;
      lo_q <= lo_d;
      dou_q <= dou_d;
      dol_q <= dol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    p_q <= p_d;
    first_q <= first_d;
    lastp_q <= lastp_d;
    ta_q <= ta_d;
    tb_q <= tb_d;
    tc_q <= tc_d;
    idx_q <= idx_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    oovf_q <= oovf_d;
  end

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem_q[pwa] <= pwd;
    end
    prd_a_q <= pmem_q[pra];
    prd_b_q <= pmem_q[prb];
  end

  always_ff @(posedge clk_i) begin
    if (uwe) begin
      umem_q[cwa] <= cwd;
    end
    urd_a_q <= umem_q[cra];
    urd_b_q <= umem_q[crb];
  end

  always_ff @(posedge clk_i) begin
    if (lwe) begin
      lmem_q[cwa] <= cwd;
    end
    lrd_a_q <= lmem_q[cra];
    lrd_b_q <= lmem_q[crb];
  end

  assign m_valid_o = ov_q;
  assign m_data_o  = odata_q;
  assign m_last_o  = olast_q;
  assign m_ovf_o   = oovf_q;

  `CHM_ASSERT(a_depths_bounded, clk_i, rst_ni, (n_q <= CW'(MAX_POINTS)) && (utop_q <= CW'(MAX_POINTS)) && (ltop_q <= CW'(MAX_POINTS)))
  `CHM_ASSERT_NXT(a_last_ends_run, clk_i, rst_ni, out_load && out_last, (st_q == chm_pkg::S_IDLE) && (n_q == '0) && !ovf_q)
  `CHM_ASSERT_IMP(a_pop_only_idle, clk_i, rst_ni, fifo_pop_o, st_q == chm_pkg::S_IDLE)

endmodule

// ===== src/convex_hull_monotone_chain_unit.sv =====
// Channel   Direction  tdata (low bit up)          tlast        tuser
// s_axis    in         point_x, point_y            last_point   -
// m_axis    out        hull_x, hull_y              last_vertex  overflow
//
// Points are taken one beat per cycle, while not full, into a four-entry queue and stored.
// A set of n points is then insertion sorted, the upper and lower chains are
// built with pop tests, and the hull vertices are emitted, all bound by the
// point memory ports.
// Reset clears all control state; no memory clearing pass is needed.
// A stalled output holds the sequencer while the input queue keeps filling.
module convex_hull_monotone_chain_unit #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // point_x, point_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // hull_x, hull_y
  output logic [((2*COORD_BITS+7)/8)*8-1:0]     m_axis_tdata_o,
  output logic                                  m_axis_tlast_o,
  // overflow
  output logic                                  m_axis_tuser_o
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = ((2 * CB + 7) / 8) * 8;
  localparam int unsigned EW = 2 * CB + 2;

  logic          full, push, fvalid, pop;
  logic [EW-1:0] entry, fdata;
  logic [2*CB-1:0] odata;

  chm_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .x_i     (s_axis_tdata_i[CB-1:0]),
    .y_i     (s_axis_tdata_i[2*CB-1:CB]),
    .last_i  (s_axis_tlast_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  chm_fifo #(.Width(EW), .Depth(4)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fvalid),
    .data_o  (fdata)
  );

  chm_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_valid_i (fvalid),
    .fifo_data_i  (fdata),
    .fifo_pop_o   (pop),
    .m_valid_o    (m_axis_tvalid_o),
    .m_ready_i    (m_axis_tready_i),
    .m_data_o     (odata),
    .m_last_o     (m_axis_tlast_o),
    .m_ovf_o      (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = DW'(odata);

endmodule
